### rtl/fan_pwm_start_tach_supervisor_core_macros.svh
// Assertion helpers for the fan supervisor core.
// Both expect aclk and aresetn in scope.
`ifndef FAN_PWM_START_TACH_SUPERVISOR_CORE_MACROS_SVH
`define FAN_PWM_START_TACH_SUPERVISOR_CORE_MACROS_SVH

// same-cycle implication
`define FPST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fpst_pkg.sv
`default_nettype none

package fpst_pkg;

    // fan modes
    localparam logic [2:0] M_OFF    = 3'd0;
    localparam logic [2:0] M_BOOST  = 3'd1;
    localparam logic [2:0] M_RUN    = 3'd2;
    localparam logic [2:0] M_UNREL  = 3'd3;
    localparam logic [2:0] M_NOTACH = 3'd4;
    localparam logic [2:0] M_LOCKED = 3'd5;
    localparam logic [2:0] M_CFGERR = 3'd6;

    // request kinds
    localparam logic [2:0] REQ_PROCESS   = 3'd0;
    localparam logic [2:0] REQ_SET       = 3'd1;
    localparam logic [2:0] REQ_TRIP      = 3'd2;
    localparam logic [2:0] REQ_CLEAR     = 3'd3;
    localparam logic [2:0] REQ_AUTHORIZE = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_PWM_PERIOD = 3'd0;
    localparam logic [2:0] CFG_MIN_DUTY   = 3'd1;
    localparam logic [2:0] CFG_MAX_DUTY   = 3'd2;
    localparam logic [2:0] CFG_BOOST_MS   = 3'd3;
    localparam logic [2:0] CFG_RPM_FACTOR = 3'd4;
    localparam logic [2:0] CFG_GRACE_MS   = 3'd5;
    localparam logic [2:0] CFG_NO_TACH_MS = 3'd6;

    localparam logic [13:0] DUTY_FULL = 14'd10000;
    localparam logic [15:0] SAT16     = 16'hFFFF;

    // compare = (x + 5000) / 10000, x < 2^30: reciprocal 2^44 / 10000 rounded up
    localparam logic [30:0] CMP_ROUND = 31'd5000;
    localparam logic [30:0] CMP_RECIP = 31'd1759218605;
    // rpm = (y + 500) / 1000, exact for y < 2^26: reciprocal 2^36 / 1000 rounded up
    localparam logic [39:0] SPD_ROUND = 40'd500;
    localparam logic [39:0] SPD_LIMIT = 40'd65536000;
    localparam logic [26:0] SPD_RECIP = 27'd68719477;

    typedef struct packed {
        logic [15:0] pwm_period;
        logic [13:0] min_duty;
        logic [13:0] max_duty;
        logic [15:0] boost_ms;
        logic [15:0] rpm_factor;
        logic [15:0] grace_ms;
        logic [15:0] no_tach_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pwm_period: 16'd999,
        min_duty:   14'd1000,
        max_duty:   14'd10000,
        boost_ms:   16'd5000,
        rpm_factor: 16'd30,
        grace_ms:   16'd400,
        no_tach_ms: 16'd1000
    };

    typedef struct packed {
        logic [2:0]  req_type;
        logic        enable_req;
        logic [13:0] duty;
        logic        fb_present;
        logic        fb_locked;
        logic [31:0] fb_seq;
        logic [23:0] fb_freq_mhz;
        logic [31:0] now_ms;
    } req_t;

    // supervisor state; rpm is kept as the frequency plus the factor in force
    // when it was captured
    typedef struct packed {
        logic [2:0]  mode;
        logic        is_enabled;
        logic [13:0] goal_duty;
        logic [13:0] driven_duty;
        logic [31:0] boost_begin;
        logic [23:0] last_freq;
        logic [15:0] last_factor;
        logic [31:0] last_tach_time;
        logic [31:0] seen_seq;
        logic [31:0] duty_change_time;
        logic        tach_good;
        logic        ever_good;
        logic        fault_latched;
        logic        restart_blocked;
    } st_t;

    localparam st_t ST_RESET = '{
        mode:             M_OFF,
        is_enabled:       1'b0,
        goal_duty:        DUTY_FULL,
        driven_duty:      14'd0,
        boost_begin:      32'd0,
        last_freq:        24'd0,
        last_factor:      16'd0,
        last_tach_time:   32'd0,
        seen_seq:         32'd0,
        duty_change_time: 32'd0,
        tach_good:        1'b0,
        ever_good:        1'b0,
        fault_latched:    1'b0,
        restart_blocked:  1'b0
    };

    // outcome of one step, handed to the arithmetic stages
    typedef struct packed {
        logic        accepted;
        logic        restart;
        logic [2:0]  mode;
        logic        is_enabled;
        logic [13:0] goal_duty;
        logic [13:0] driven_duty;
        logic [23:0] last_freq;
        logic [15:0] last_factor;
        logic        tach_good;
        logic        fault_latched;
        logic        restart_blocked;
        logic [31:0] now_ms;
        logic [31:0] last_tach_time;
    } rec_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  fan_state;
        logic        fan_enabled;
        logic [13:0] set_duty;
        logic [13:0] out_duty;
        logic [15:0] pwm_compare;
        logic [23:0] tach_freq_out;
        logic [15:0] rpm_out;
        logic        tach_ok;
        logic [15:0] tach_age;
        logic [1:0]  lock_flags;
        logic        feedback_restart;
    } res_t;

    function automatic st_t clear_run(input st_t s);
        st_t r;
        r = ST_RESET;
        r.fault_latched   = s.fault_latched;
        r.restart_blocked = s.restart_blocked;
        return r;
    endfunction

    function automatic st_t clear_tach(input st_t s);
        st_t r;
        r = s;
        r.last_freq      = 24'd0;
        r.last_factor    = 16'd0;
        r.last_tach_time = 32'd0;
        r.tach_good      = 1'b0;
        r.ever_good      = 1'b0;
        return r;
    endfunction

    function automatic st_t lose_tach(input st_t s);
        st_t r;
        r = s;
        r.mode        = M_NOTACH;
        r.last_freq   = 24'd0;
        r.last_factor = 16'd0;
        r.tach_good   = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/fan_pwm_start_tach_supervisor_core.sv
// Fan PWM supervisor core.
// Requests enter on the s_ stream (s_tuser = kind, s_tdata = request fields);
// each produces exactly one result transaction on the m_ stream, in order.
// Configuration registers are written on the cfg_ channel (always ready) and
// should only change while no request is in flight.
// Datapath: input register, decision stage (state updated here), product
// stage, reciprocal-divide stage feeding the output register.
// Throughput: one request per cycle unless m_tready stalls it; the decision
// stage closes the state loop itself, so requests never wait on each other.
// When m_tready is low the stages fill up and s_tready drops once all four
// registers hold a transaction; nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline, restores the
// register defaults and returns the supervisor to off with no faults.
`default_nettype none

`include "fan_pwm_start_tach_supervisor_core_macros.svh"

module fan_pwm_start_tach_supervisor_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // enable_req[0], duty[14:1], fb_present[15], fb_locked[16], fb_seq[48:17],
    // fb_freq_mhz[72:49], now_ms[104:73], zero pad [111:105]
    input  wire logic [111:0] s_tdata,
    // req_type[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accepted[0], fan_state[3:1], fan_enabled[4], goal duty[18:5],
    // driven duty[32:19], pwm_compare[48:33], tach_freq_out[72:49],
    // rpm_out[88:73], tach_ok[89], tach age[105:90], lock_flags[107:106],
    // feedback_restart[108], zero pad [111:109]
    output logic [111:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import fpst_pkg::*;

    cfg_t cfg_reg;
    req_t in_req_reg;
    logic in_vld_reg;
    logic in_vld_next;
    logic a_vld_reg;
    logic a_vld_next;
    logic b_vld_reg;
    logic b_vld_next;
    logic m_vld_reg;
    logic m_vld_next;
    logic adv1;
    logic adv2;
    logic adv3;
    rec_t rec;
    res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PWM_PERIOD: cfg_reg.pwm_period <= cfg_data;
                CFG_MIN_DUTY:   cfg_reg.min_duty   <= cfg_data[13:0];
                CFG_MAX_DUTY:   cfg_reg.max_duty   <= cfg_data[13:0];
                CFG_BOOST_MS:   cfg_reg.boost_ms   <= cfg_data;
                CFG_RPM_FACTOR: cfg_reg.rpm_factor <= cfg_data;
                CFG_GRACE_MS:   cfg_reg.grace_ms   <= cfg_data;
                CFG_NO_TACH_MS: cfg_reg.no_tach_ms <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // each stage moves forward when the next one is empty or moving too
    assign adv3 = b_vld_reg && (!m_vld_reg || m_tready);
    assign adv2 = a_vld_reg && (!b_vld_reg || adv3);
    assign adv1 = in_vld_reg && (!a_vld_reg || adv2);
    assign s_tready = !in_vld_reg || adv1;

    always_comb begin
        in_vld_next = (s_tvalid && s_tready) ? 1'b1 : (adv1 ? 1'b0 : in_vld_reg);
        a_vld_next  = adv1 ? 1'b1 : (adv2 ? 1'b0 : a_vld_reg);
        b_vld_next  = adv2 ? 1'b1 : (adv3 ? 1'b0 : b_vld_reg);
        m_vld_next  = adv3 ? 1'b1 : (m_tready ? 1'b0 : m_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            a_vld_reg  <= a_vld_next;
            b_vld_reg  <= b_vld_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg.req_type    <= s_tuser;
            in_req_reg.enable_req  <= s_tdata[0];
            in_req_reg.duty        <= s_tdata[14:1];
            in_req_reg.fb_present  <= s_tdata[15];
            in_req_reg.fb_locked   <= s_tdata[16];
            in_req_reg.fb_seq      <= s_tdata[48:17];
            in_req_reg.fb_freq_mhz <= s_tdata[72:49];
            in_req_reg.now_ms      <= s_tdata[104:73];
        end
    end

    fpst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (adv1),
        .req     (in_req_reg),
        .cfg     (cfg_reg),
        .rec     (rec)
    );

    fpst_scale u_scale (
        .aclk       (aclk),
        .b_en       (adv2),
        .c_en       (adv3),
        .rec        (rec),
        .pwm_period (cfg_reg.pwm_period),
        .res        (res)
    );

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {3'd0, res.feedback_restart, res.lock_flags, res.tach_age,
                       res.tach_ok, res.rpm_out, res.tach_freq_out, res.pwm_compare,
                       res.out_duty, res.set_duty, res.fan_enabled,
                       res.fan_state, res.accepted};

    `FPST_ASSERT_NEXT(a_stall_keeps_b, b_vld_reg && m_vld_reg && !m_tready, b_vld_reg, "product stage dropped a transaction during stall")
    `FPST_ASSERT_NOW(a_fault_blocks_restart, m_tvalid && m_tdata[106], m_tdata[107], "fault latched without restart inhibit")
    `FPST_ASSERT_NOW(a_zero_duty_zero_cmp, m_tvalid && m_tdata[32:19] == 14'd0, m_tdata[48:33] == 16'd0, "nonzero compare for zero applied duty")
    `FPST_ASSERT_NOW(a_off_age_sat, m_tvalid && m_tdata[3:1] == M_OFF, m_tdata[105:90] == SAT16, "tach age not saturated while off")

endmodule

`default_nettype wire

### rtl/fpst_ctrl.sv
`default_nettype none

// Supervisor decision logic: one request per step, state and step record
// registered together.
module fpst_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire fpst_pkg::req_t req,
    input  wire fpst_pkg::cfg_t cfg,
    output fpst_pkg::rec_t     rec
);
    import fpst_pkg::*;

    st_t  st_reg;
    st_t  st_next;
    rec_t rec_reg;
    rec_t rec_next;

    always_comb begin
        st_t         s;
        logic        acc;
        logic        rst;
        logic        cfg_ok;
        logic        fire;
        logic [31:0] sync_seq;
        logic [31:0] since_tach;
        logic [31:0] since_change;
        logic [31:0] since_boost;
        logic [31:0] now;

        s        = st_reg;
        acc      = 1'b0;
        rst      = 1'b0;
        now      = req.now_ms;
        sync_seq = req.fb_present ? req.fb_seq : 32'd0;
        cfg_ok   = (cfg.pwm_period != 16'd0) && (cfg.min_duty <= cfg.max_duty);

        if (!cfg_ok) begin
            s.mode = M_CFGERR;
        end else if (s.mode == M_CFGERR) begin
            s = clear_run(s);
        end

        since_tach   = now - s.last_tach_time;
        since_change = now - s.duty_change_time;
        since_boost  = now - s.boost_begin;
        fire = s.ever_good ? (since_tach >= {16'd0, cfg.no_tach_ms})
                           : (since_change >= {16'd0, cfg.grace_ms});

        case (req.req_type)
            REQ_PROCESS: begin
                acc = 1'b1;
                if (!cfg_ok) begin
                    acc = 1'b1;
                end else if (s.mode == M_BOOST) begin
                    if (since_boost >= {16'd0, cfg.boost_ms}) begin
                        s.driven_duty      = s.goal_duty;
                        rst                = 1'b1;
                        s.seen_seq         = sync_seq;
                        s.tach_good        = 1'b0;
                        s.mode             = M_UNREL;
                        s.duty_change_time = now;
                    end
                end else if (s.is_enabled && s.driven_duty != 14'd0) begin
                    if (req.fb_present && req.fb_locked) begin
                        if (req.fb_seq != s.seen_seq) begin
                            s.last_freq      = req.fb_freq_mhz;
                            s.last_factor    = cfg.rpm_factor;
                            s.last_tach_time = now;
                            s.seen_seq       = req.fb_seq;
                            s.tach_good      = 1'b1;
                            s.ever_good      = 1'b1;
                            s.mode           = M_RUN;
                        end else if (fire) begin
                            s = lose_tach(s);
                        end
                    end else begin
                        s.tach_good = 1'b0;
                        if (fire) begin
                            s = lose_tach(s);
                        end else if (since_boost >= {16'd0, cfg.boost_ms}) begin
                            s.mode = M_UNREL;
                        end
                    end
                end
            end
            REQ_SET: begin
                if (!cfg_ok || (req.enable_req && (s.fault_latched || s.restart_blocked))) begin
                    acc = 1'b0;
                end else if (!req.enable_req) begin
                    if (req.duty == 14'd0) begin
                        acc           = 1'b1;
                        s.driven_duty = 14'd0;
                        s.is_enabled  = 1'b0;
                        s.mode        = s.fault_latched ? M_LOCKED : M_OFF;
                        s             = clear_tach(s);
                    end
                end else if (req.duty == 14'd0) begin
                    if (!s.is_enabled) begin
                        rst        = 1'b1;
                        s.seen_seq = sync_seq;
                    end
                    acc           = 1'b1;
                    s.driven_duty = 14'd0;
                    s.is_enabled  = 1'b1;
                    s.mode        = M_OFF;
                    s.goal_duty   = 14'd0;
                    s             = clear_tach(s);
                end else if (req.duty < cfg.min_duty || req.duty > cfg.max_duty) begin
                    acc = 1'b0;
                end else if (!s.is_enabled) begin
                    // start from idle: boost at the configured maximum duty first
                    acc                = 1'b1;
                    rst                = 1'b1;
                    s.seen_seq         = sync_seq;
                    s.driven_duty      = cfg.max_duty;
                    s.is_enabled       = 1'b1;
                    s.boost_begin      = now;
                    s.mode             = M_BOOST;
                    s                  = clear_tach(s);
                    s.duty_change_time = now;
                    s.goal_duty        = req.duty;
                end else begin
                    acc = 1'b1;
                    if (s.goal_duty != req.duty) begin
                        s.goal_duty = req.duty;
                        // during boost the new duty waits for the boost to end
                        if (s.mode != M_BOOST) begin
                            s.driven_duty      = req.duty;
                            rst                = 1'b1;
                            s.seen_seq         = sync_seq;
                            s.tach_good        = 1'b0;
                            s.duty_change_time = now;
                            s.mode             = M_RUN;
                        end
                    end
                end
            end
            REQ_TRIP: begin
                s.fault_latched   = 1'b1;
                s.restart_blocked = 1'b1;
                if (cfg_ok) begin
                    acc           = 1'b1;
                    s.driven_duty = 14'd0;
                    s.goal_duty   = 14'd0;
                    s.is_enabled  = 1'b0;
                    s             = clear_tach(s);
                    s.mode        = M_LOCKED;
                end
            end
            REQ_CLEAR: begin
                if (cfg_ok) begin
                    acc               = 1'b1;
                    s.fault_latched   = 1'b0;
                    s.restart_blocked = 1'b1;
                    s.is_enabled      = 1'b0;
                    s.goal_duty       = 14'd0;
                    s.driven_duty     = 14'd0;
                    s                 = clear_tach(s);
                    s.mode            = M_OFF;
                end
            end
            REQ_AUTHORIZE: begin
                if (cfg_ok && !s.fault_latched) begin
                    acc               = 1'b1;
                    s.restart_blocked = 1'b0;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase

        st_next = s;

        rec_next.accepted        = acc;
        rec_next.restart         = rst;
        rec_next.mode            = s.mode;
        rec_next.is_enabled      = s.is_enabled;
        rec_next.goal_duty       = s.goal_duty;
        rec_next.driven_duty     = s.driven_duty;
        rec_next.last_freq       = s.last_freq;
        rec_next.last_factor     = s.last_factor;
        rec_next.tach_good       = s.tach_good;
        rec_next.fault_latched   = s.fault_latched;
        rec_next.restart_blocked = s.restart_blocked;
        rec_next.now_ms          = now;
        rec_next.last_tach_time  = s.last_tach_time;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire

### rtl/fpst_scale.sv
`default_nettype none

// Two arithmetic stages after the decision: products and tach age first,
// then constant division by reciprocal multiply with saturation.
module fpst_scale (
    input  wire logic           aclk,
    input  wire logic           b_en,
    input  wire logic           c_en,
    input  wire fpst_pkg::rec_t rec,
    input  wire logic [15:0]    pwm_period,
    output fpst_pkg::res_t      res
);
    import fpst_pkg::*;

    res_t        b_res_reg;
    res_t        b_res_next;
    logic [29:0] b_cmp_reg;
    logic [29:0] b_cmp_next;
    logic [39:0] b_spd_reg;
    logic [39:0] b_spd_next;
    res_t        c_res_reg;
    res_t        c_res_next;

    always_comb begin
        logic [30:0] cmp_sum;
        logic [31:0] age_full;

        cmp_sum    = 31'({1'b0, pwm_period} + 17'd1) * 31'(rec.driven_duty) + CMP_ROUND;
        b_cmp_next = cmp_sum[29:0];
        b_spd_next = 40'(rec.last_freq) * 40'(rec.last_factor) + SPD_ROUND;

        age_full = rec.now_ms - rec.last_tach_time;

        b_res_next.accepted         = rec.accepted;
        b_res_next.fan_state        = rec.mode;
        b_res_next.fan_enabled      = rec.is_enabled;
        b_res_next.set_duty         = rec.goal_duty;
        b_res_next.out_duty         = rec.driven_duty;
        b_res_next.pwm_compare      = 16'd0;
        b_res_next.tach_freq_out    = rec.last_freq;
        b_res_next.rpm_out          = 16'd0;
        b_res_next.tach_ok          = rec.tach_good;
        if (rec.mode == M_OFF || rec.last_tach_time == 32'd0 || age_full[31:16] != 16'd0) begin
            b_res_next.tach_age = SAT16;
        end else begin
            b_res_next.tach_age = age_full[15:0];
        end
        b_res_next.lock_flags       = {rec.restart_blocked, rec.fault_latched};
        b_res_next.feedback_restart = rec.restart;
    end

    always_comb begin
        logic [60:0] cmp_prod;
        logic [52:0] spd_prod;
        logic [16:0] cmp_q;

        cmp_prod = 61'(b_cmp_reg) * 61'(CMP_RECIP);
        spd_prod = 53'(b_spd_reg[25:0]) * 53'(SPD_RECIP);
        cmp_q    = cmp_prod[60:44];

        c_res_next             = b_res_reg;
        c_res_next.pwm_compare = cmp_q[16] ? SAT16 : cmp_q[15:0];
        c_res_next.rpm_out     = (b_spd_reg >= SPD_LIMIT) ? SAT16 : spd_prod[51:36];
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            b_res_reg <= b_res_next;
            b_cmp_reg <= b_cmp_next;
            b_spd_reg <= b_spd_next;
        end
        if (c_en) begin
            c_res_reg <= c_res_next;
        end
    end

    assign res = c_res_reg;

endmodule

`default_nettype wire

### test/tb_fan_pwm_start_tach_supervisor_core.sv
`timescale 1ns / 1ps

module tb_fan_pwm_start_tach_supervisor_core;
    import fpst_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned MAX_PRINTED    = 200;

    // request kinds the block must reject
    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

    localparam logic [1:0] LOCK_NONE    = 2'b00;
    localparam logic [1:0] LOCK_INHIBIT = 2'b10;
    localparam logic [1:0] LOCK_BOTH    = 2'b11;

    // field order matches the stream packing, lowest field last
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now;
        logic [23:0] freq;
        logic [31:0] seq;
        logic        locked;
        logic        present;
        logic [13:0] duty;
        logic        en;
    } fan_req_t;

    typedef struct packed {
        logic        restart;
        logic [1:0]  lock;
        logic [15:0] age;
        logic        tach_ok;
        logic [15:0] rpm;
        logic [23:0] freq;
        logic [15:0] compare;
        logic [13:0] applied;
        logic [13:0] target;
        logic        enabled;
        logic [2:0]  state;
        logic        accepted;
    } fan_res_t;

    typedef struct packed {
        fan_req_t req;
        logic     typed;
        fan_res_t res;
    } script_row_t;

    typedef struct packed {
        logic [15:0] period;
        logic [13:0] min_duty;
        logic [13:0] max_duty;
        logic [15:0] boost;
        logic [15:0] factor;
        logic [15:0] grace;
        logic [15:0] no_tach;
    } fan_cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        enabled;
        logic [13:0] goal;
        logic [13:0] driven;
        logic [31:0] boost_t0;
        logic [23:0] freq;
        logic [15:0] rpm;
        logic [31:0] tach_t;
        logic [31:0] seq;
        logic [31:0] change_t;
        logic        good;
        logic        ever;
        logic        fault;
        logic        blocked;
    } sup_t;

    localparam sup_t SUP_RESET = '{mode: M_OFF, goal: DUTY_FULL, default: '0};
    localparam fan_res_t NO_RES = '0;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata = '0;
    logic [2:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [111:0]  m_tdata;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [15:0]   cfg_data = '0;

    fan_cfg_t cfg = '{16'd999, 14'd1000, 14'd10000, 16'd5000, 16'd30, 16'd400, 16'd1000};
    sup_t sup = SUP_RESET;

    fan_res_t    pending_status [$];
    script_row_t script [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    logic [31:0] now_t;
    logic [31:0] seq_t;

    fan_pwm_start_tach_supervisor_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial forever #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic void drop_tach();
        sup.freq    = '0;
        sup.rpm     = '0;
        sup.tach_t  = '0;
        sup.good    = 1'b0;
        sup.ever    = 1'b0;
    endfunction

    // before the first good reading the grace window applies, after it the no-tach age
    function automatic logic tach_timed_out(input logic [31:0] now);
        logic [31:0] since_tach;
        logic [31:0] since_change;
        logic        late;
        since_tach   = now - sup.tach_t;
        since_change = now - sup.change_t;
        late = sup.ever ? (since_tach >= 32'(cfg.no_tach)) : (since_change >= 32'(cfg.grace));
        if (late) begin
            sup.mode = M_NOTACH;
            sup.freq = '0;
            sup.rpm  = '0;
            sup.good = 1'b0;
        end
        return late;
    endfunction

    function automatic fan_res_t supervise(input fan_req_t r);
        fan_res_t    o;
        logic [31:0] sync_seq;
        logic [31:0] since_boost;
        logic [31:0] since_tach;
        logic [63:0] wide;
        logic        cfg_ok;
        logic        acc;
        logic        restart;
        logic        keep_fault;
        logic        keep_blocked;
        sync_seq    = r.present ? r.seq : 32'd0;
        since_boost = r.now - sup.boost_t0;
        acc         = 1'b0;
        restart     = 1'b0;
        cfg_ok      = (cfg.period != 16'd0) && (cfg.min_duty <= cfg.max_duty);

        if (!cfg_ok) begin
            sup.mode = M_CFGERR;
        end else if (sup.mode == M_CFGERR) begin
            // recovered from a bad setup: everything but the lock flags restarts
            keep_fault   = sup.fault;
            keep_blocked = sup.blocked;
            sup          = SUP_RESET;
            sup.fault    = keep_fault;
            sup.blocked  = keep_blocked;
        end

        case (r.kind)
            REQ_PROCESS: begin
                acc = 1'b1;
                if (!cfg_ok) begin
                end else if (sup.mode == M_BOOST) begin
                    if (since_boost >= 32'(cfg.boost)) begin
                        sup.driven   = sup.goal;
                        restart      = 1'b1;
                        sup.seq      = sync_seq;
                        sup.good     = 1'b0;
                        sup.mode     = M_UNREL;
                        sup.change_t = r.now;
                    end
                end else if (sup.enabled && sup.driven != 14'd0) begin
                    if (r.present && r.locked) begin
                        if (r.seq != sup.seq) begin
                            wide = (64'(r.freq) * 64'(cfg.factor) + 64'd500) / 64'd1000;
                            sup.freq   = r.freq;
                            sup.rpm    = (wide > 64'd65535) ? SAT16 : wide[15:0];
                            sup.tach_t = r.now;
                            sup.seq    = r.seq;
                            sup.good   = 1'b1;
                            sup.ever   = 1'b1;
                            sup.mode   = M_RUN;
                        end else begin
                            void'(tach_timed_out(r.now));
                        end
                    end else begin
                        sup.good = 1'b0;
                        if (!tach_timed_out(r.now) && since_boost >= 32'(cfg.boost))
                            sup.mode = M_UNREL;
                    end
                end
            end
            REQ_SET: begin
                if (!cfg_ok || (r.en && (sup.fault || sup.blocked))) begin
                end else if (!r.en) begin
                    if (r.duty == 14'd0) begin
                        acc         = 1'b1;
                        sup.driven  = '0;
                        sup.enabled = 1'b0;
                        sup.mode    = sup.fault ? M_LOCKED : M_OFF;
                        drop_tach();
                    end
                end else if (r.duty == 14'd0) begin
                    if (!sup.enabled) begin
                        restart = 1'b1;
                        sup.seq = sync_seq;
                    end
                    acc         = 1'b1;
                    sup.driven  = '0;
                    sup.enabled = 1'b1;
                    sup.mode    = M_OFF;
                    sup.goal    = '0;
                    drop_tach();
                end else if (r.duty < cfg.min_duty || r.duty > cfg.max_duty) begin
                end else if (!sup.enabled) begin
                    acc          = 1'b1;
                    restart      = 1'b1;
                    sup.seq      = sync_seq;
                    sup.driven   = cfg.max_duty;
                    sup.enabled  = 1'b1;
                    sup.boost_t0 = r.now;
                    sup.mode     = M_BOOST;
                    drop_tach();
                    sup.change_t = r.now;
                    sup.goal     = r.duty;
                end else begin
                    acc = 1'b1;
                    if (sup.goal != r.duty) begin
                        sup.goal = r.duty;
                        // during boost the new duty waits for the boost to end
                        if (sup.mode != M_BOOST) begin
                            sup.driven   = r.duty;
                            restart      = 1'b1;
                            sup.seq      = sync_seq;
                            sup.good     = 1'b0;
                            sup.change_t = r.now;
                            sup.mode     = M_RUN;
                        end
                    end
                end
            end
            REQ_TRIP: begin
                sup.fault   = 1'b1;
                sup.blocked = 1'b1;
                if (cfg_ok) begin
                    acc         = 1'b1;
                    sup.driven  = '0;
                    sup.goal    = '0;
                    sup.enabled = 1'b0;
                    drop_tach();
                    sup.mode    = M_LOCKED;
                end
            end
            REQ_CLEAR: begin
                if (cfg_ok) begin
                    acc         = 1'b1;
                    sup.fault   = 1'b0;
                    sup.blocked = 1'b1;
                    sup.enabled = 1'b0;
                    sup.goal    = '0;
                    sup.driven  = '0;
                    drop_tach();
                    sup.mode    = M_OFF;
                end
            end
            REQ_AUTHORIZE: begin
                if (cfg_ok && !sup.fault) begin
                    acc         = 1'b1;
                    sup.blocked = 1'b0;
                end
            end
            default: begin
            end
        endcase

        wide = ((64'(cfg.period) + 64'd1) * 64'(sup.driven) + 64'd5000) / 64'd10000;
        o.compare = (wide > 64'd65535) ? SAT16 : wide[15:0];
        since_tach = r.now - sup.tach_t;
        if (sup.mode == M_OFF || sup.tach_t == 32'd0 || since_tach > 32'd65535)
            o.age = SAT16;
        else
            o.age = since_tach[15:0];
        o.accepted = acc;
        o.state    = sup.mode;
        o.enabled  = sup.enabled;
        o.target   = sup.goal;
        o.applied  = sup.driven;
        o.freq     = sup.freq;
        o.rpm      = sup.rpm;
        o.tach_ok  = sup.good;
        o.lock     = {sup.blocked, sup.fault};
        o.restart  = restart;
        return o;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_error($sformatf("result %0d %s: got %0d, expected %0d",
                                 results_seen, name, got, want));
    endtask

    always @(posedge aclk) begin : result_check
        fan_res_t got;
        fan_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[108:0];
            if (pending_status.size() == 0) begin
                note_error($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
                want = pending_status.pop_front();
                check_field("accepted", 32'(got.accepted), 32'(want.accepted));
                check_field("fan_state", 32'(got.state), 32'(want.state));
                check_field("fan_enabled", 32'(got.enabled), 32'(want.enabled));
                check_field("goal_duty", 32'(got.target), 32'(want.target));
                check_field("drive_duty", 32'(got.applied), 32'(want.applied));
                check_field("pwm_compare", 32'(got.compare), 32'(want.compare));
                check_field("tach_freq", 32'(got.freq), 32'(want.freq));
                check_field("rpm", 32'(got.rpm), 32'(want.rpm));
                check_field("tach_ok", 32'(got.tach_ok), 32'(want.tach_ok));
                check_field("tach_age", 32'(got.age), 32'(want.age));
                check_field("lock_flags", 32'(got.lock), 32'(want.lock));
                check_field("feedback_restart", 32'(got.restart), 32'(want.restart));
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_req(input fan_req_t r, input logic typed, input fan_res_t want);
        fan_res_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {7'd0, r[104:0]};
        do @(posedge aclk); while (!s_tready);
        predicted = supervise(r);
        pending_status.push_back(typed ? want : predicted);
    endtask

    // stop sending and let the pipeline run dry
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_PWM_PERIOD: cfg.period   = val;
            CFG_MIN_DUTY:   cfg.min_duty = val[13:0];
            CFG_MAX_DUTY:   cfg.max_duty = val[13:0];
            CFG_BOOST_MS:   cfg.boost    = val;
            CFG_RPM_FACTOR: cfg.factor   = val;
            CFG_GRACE_MS:   cfg.grace    = val;
            CFG_NO_TACH_MS: cfg.no_tach  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setup(input logic [15:0] period, input logic [15:0] min_d,
                              input logic [15:0] max_d, input logic [15:0] boost,
                              input logic [15:0] factor, input logic [15:0] grace,
                              input logic [15:0] no_tach);
        write_reg(CFG_PWM_PERIOD, period);
        write_reg(CFG_MIN_DUTY, min_d);
        write_reg(CFG_MAX_DUTY, max_d);
        write_reg(CFG_BOOST_MS, boost);
        write_reg(CFG_RPM_FACTOR, factor);
        write_reg(CFG_GRACE_MS, grace);
        write_reg(CFG_NO_TACH_MS, no_tach);
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic fan_req_t rq(input logic [2:0] k, input logic e, input logic [13:0] d,
                                    input logic p, input logic l, input logic [31:0] s,
                                    input logic [23:0] f, input logic [31:0] n);
        return '{kind: k, now: n, freq: f, seq: s, locked: l, present: p, duty: d, en: e};
    endfunction

    // result with no tach, no PWM and the fan disabled
    function automatic fan_res_t quiet_res(input logic acc, input logic [2:0] st,
                                           input logic [13:0] goal, input logic [1:0] flags);
        return '{accepted: acc, state: st, target: goal, age: SAT16, lock: flags, default: '0};
    endfunction

    // mostly well-formed supervision traffic: time moves forward on the scale of the
    // configured timeouts and the tach sequence number advances most of the time
    function automatic fan_req_t rand_req();
        fan_req_t    r;
        int unsigned pick;
        int unsigned span;
        span = cfg.boost;
        if (cfg.no_tach > span) span = cfg.no_tach;
        if (cfg.grace > span) span = cfg.grace;
        span = span / 6 + 8;
        case ($urandom_range(0, 39))
            0:       now_t = now_t + $urandom();
            1:       now_t = now_t + $urandom_range(0, 140000);
            default: now_t = now_t + $urandom_range(0, span);
        endcase
        if ($urandom_range(0, 2) != 0)
            seq_t = ($urandom_range(0, 19) == 0) ? $urandom() : seq_t + $urandom_range(1, 3);

        r.kind    = REQ_PROCESS;
        r.now     = now_t;
        r.seq     = seq_t;
        r.en      = 1'($urandom_range(0, 1));
        r.duty    = 14'($urandom_range(0, 10000));
        r.present = ($urandom_range(0, 9) != 0);
        r.locked  = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2: r.freq = 24'($urandom());
            3, 4:    r.freq = 24'($urandom_range(0, 2000));
            default: r.freq = 24'($urandom_range(0, 200000));
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            r.kind = REQ_PROCESS;
        end else if (pick < 80) begin
            r.kind = REQ_SET;
            r.en   = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 9))
                0:       r.duty = 14'd0;
                1:       r.duty = 14'($urandom_range(0, 10000));
                default: r.duty = r.en ? 14'($urandom_range(cfg.min_duty, cfg.max_duty)) : 14'd0;
            endcase
        end else if (pick < 84) begin
            r.kind = REQ_TRIP;
        end else if (pick < 89) begin
            r.kind = REQ_CLEAR;
        end else if (pick < 97) begin
            r.kind = REQ_AUTHORIZE;
        end else begin
            r.kind    = 3'($urandom_range(0, 7));
            r.present = 1'($urandom_range(0, 1));
            r.locked  = 1'($urandom_range(0, 1));
            r.seq     = $urandom();
            r.now     = $urandom();
            now_t     = r.now;
        end
        return r;
    endfunction

    initial begin : stimulus
        int unsigned batch;
        script = '{
            '{rq(REQ_PROCESS, 0, 0, 0, 0, 0, 0, 100), 1'b1,
              quiet_res(1'b1, M_OFF, DUTY_FULL, LOCK_NONE)},
            '{rq(REQ_UNKNOWN_LO, 1, 1234, 1, 1, 7, 500, 200), 1'b1,
              quiet_res(1'b0, M_OFF, DUTY_FULL, LOCK_NONE)},
            '{rq(REQ_UNKNOWN_HI, 1, 10000, 1, 1, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF),
              1'b1, quiet_res(1'b0, M_OFF, DUTY_FULL, LOCK_NONE)},
            // duty below the accepted range
            '{rq(REQ_SET, 1, 500, 0, 0, 0, 0, 300), 1'b1,
              quiet_res(1'b0, M_OFF, DUTY_FULL, LOCK_NONE)},
            '{rq(REQ_SET, 1, 10000, 1, 1, 5, 0, 1000), 1'b0, NO_RES},
            '{rq(REQ_PROCESS, 0, 0, 1, 1, 6, 100000, 2000), 1'b0, NO_RES},
            // new target while boosting is held back
            '{rq(REQ_SET, 1, 1000, 0, 0, 0, 0, 2500), 1'b0, NO_RES},
            '{rq(REQ_PROCESS, 0, 0, 1, 1, 7, 100000, 6000), 1'b0, NO_RES},
            '{rq(REQ_PROCESS, 0, 0, 1, 1, 8, 24'hFF_FFFF, 6100), 1'b0, NO_RES},
            '{rq(REQ_PROCESS, 0, 0, 1, 1, 8, 555, 6200), 1'b0, NO_RES},
            '{rq(REQ_PROCESS, 0, 0, 0, 0, 8, 0, 6300), 1'b0, NO_RES},
            '{rq(REQ_PROCESS, 0, 0, 1, 0, 9, 0, 7200), 1'b0, NO_RES},
            '{rq(REQ_SET, 1, 10000, 1, 1, 9, 0, 7250), 1'b0, NO_RES},
            '{rq(REQ_PROCESS, 0, 0, 1, 1, 10, 0, 77250), 1'b0, NO_RES},
            // stale tach long enough to saturate the age
            '{rq(REQ_PROCESS, 0, 0, 1, 1, 10, 0, 177250), 1'b0, NO_RES},
            '{rq(REQ_SET, 0, 5, 0, 0, 0, 0, 177300), 1'b0, NO_RES},
            '{rq(REQ_SET, 0, 0, 0, 0, 0, 0, 177400), 1'b0, NO_RES},
            '{rq(REQ_SET, 1, 0, 1, 1, 11, 0, 177500), 1'b0, NO_RES},
            '{rq(REQ_TRIP, 0, 0, 0, 0, 0, 0, 177600), 1'b1,
              quiet_res(1'b1, M_LOCKED, 14'd0, LOCK_BOTH)},
            '{rq(REQ_SET, 1, 5000, 0, 0, 0, 0, 177700), 1'b1,
              quiet_res(1'b0, M_LOCKED, 14'd0, LOCK_BOTH)},
            '{rq(REQ_AUTHORIZE, 0, 0, 0, 0, 0, 0, 177800), 1'b1,
              quiet_res(1'b0, M_LOCKED, 14'd0, LOCK_BOTH)},
            '{rq(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 177900), 1'b1,
              quiet_res(1'b1, M_OFF, 14'd0, LOCK_INHIBIT)},
            // still inhibited until authorized
            '{rq(REQ_SET, 1, 5000, 0, 0, 0, 0, 178000), 1'b1,
              quiet_res(1'b0, M_OFF, 14'd0, LOCK_INHIBIT)},
            '{rq(REQ_AUTHORIZE, 0, 0, 0, 0, 0, 0, 178100), 1'b1,
              quiet_res(1'b1, M_OFF, 14'd0, LOCK_NONE)},
            '{rq(REQ_SET, 1, 5000, 1, 1, 12, 0, 32'hFFFF_FF00), 1'b0, NO_RES}
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) send_req(script[i].req, script[i].typed, script[i].res);

        // random traffic starts just before the millisecond counter wraps
        now_t = 32'hFFFF_FF00;
        seq_t = 32'd100;
        for (int ph = 0; ph < 7; ph++) begin
            if (ph != 0) settle();
            case (ph)
                0: begin
                    snd_idle_pct = 0; rcv_stall_pct = 0; batch = 150;
                end
                1: begin
                    load_setup(16'd65535, 16'd0, 16'd10000, 16'd50, 16'd65535, 16'd30, 16'd100);
                    snd_idle_pct = 80; rcv_stall_pct = 0; batch = 120;
                end
                2: begin
                    load_setup(16'd1, 16'd5000, 16'd5000, 16'd0, 16'd1, 16'd0, 16'd0);
                    snd_idle_pct = 0; rcv_stall_pct = 80; batch = 120;
                end
                3: begin
                    load_setup(16'd999, 16'd2000, 16'd8000, 16'd65535, 16'd60,
                               16'd65535, 16'd65535);
                    snd_idle_pct = 38; rcv_stall_pct = 38; batch = 120;
                end
                4: begin
                    // min above max: everything but a process request is refused; trip still latches the fault
                    load_setup(16'd500, 16'd10000, 16'd0, 16'd100, 16'd30, 16'd50, 16'd200);
                    snd_idle_pct = 38; rcv_stall_pct = 38; batch = 40;
                end
                5: begin
                    load_setup(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 5000)),
                               16'($urandom_range(5000, 10000)), 16'($urandom_range(0, 2000)),
                               16'($urandom_range(1, 65535)), 16'($urandom_range(0, 2000)),
                               16'($urandom_range(0, 3000)));
                    snd_idle_pct = 0; rcv_stall_pct = 0; batch = 120;
                end
                default: begin
                    load_setup(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 5000)),
                               16'($urandom_range(5000, 10000)), 16'($urandom_range(0, 2000)),
                               16'($urandom_range(1, 65535)), 16'($urandom_range(0, 2000)),
                               16'($urandom_range(0, 3000)));
                    snd_idle_pct = 38; rcv_stall_pct = 38; batch = 70;
                end
            endcase
            for (int unsigned n = 0; n < batch; n++) begin
                if ($urandom_range(0, 149) == 0) settle();
                send_req(rand_req(), 1'b0, NO_RES);
            end
        end

        settle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/fpst_pkg.sv
rtl/fpst_ctrl.sv
rtl/fpst_scale.sv
rtl/fan_pwm_start_tach_supervisor_core.sv
test/tb_fan_pwm_start_tach_supervisor_core.sv
